>>> design/mtfs_pkg.sv
// Package for the move-to-front key set: default sizes, request codes,
// controller states and the control word broadcast to the slot cells.
// No dependencies.
package mtfs_pkg;

    // Default sizes for the top-level parameters
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    // Fixed widths of the channel fields
    localparam int KEY_PORT_W = 32;
    localparam int OCC_W      = 5;

    // Request codes; the fourth code is ignored
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_UPD
    } t_state;

    // What every cell does in the update cycle
    typedef enum logic [1:0] {
        MODE_NONE,     // hold
        MODE_MTF,      // move a held key to the front
        MODE_INSERT,   // push a new key in at the front
        MODE_REMOVE    // close the gap behind a removed key
    } t_cell_mode;

    // Control word shared by all cells
    typedef struct packed {
        logic       cmp;   // compare the incoming key this cycle
        logic       upd;   // apply the shift this cycle
        t_cell_mode mode;
    } t_cell_ctl;

endpackage

>>> design/mtfs_cell.sv
// One slot of the move-to-front chain: holds a key, compares it against
// the request key and takes its neighbor's key on a shift. Uses mtfs_pkg.
module mtfs_cell
    import mtfs_pkg::*;
#(
    parameter int IDX = 0,
    parameter int KW  = 32,
    parameter int CW  = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_count,
    input  logic [KW-1:0] i_cmp_key,
    input  logic [KW-1:0] i_prev_key,
    input  logic [KW-1:0] i_next_key,
    input  logic          i_hi_seen,
    input  logic          i_lo_seen,
    output logic [KW-1:0] o_key,
    output logic          o_hi_seen,
    output logic          o_lo_seen
);

    logic [KW-1:0] r_key;
    logic          r_hit;
    logic          w_in_use;
    logic          w_le_count;

    // Slot holds a key while its index is below the count
    assign w_in_use   = (i_count > CW'(IDX));
    assign w_le_count = (CW'(IDX) <= i_count);

    // Pass hit flags down both directions of the chain
    assign o_hi_seen = i_hi_seen | r_hit;
    assign o_lo_seen = i_lo_seen | r_hit;
    assign o_key     = r_key;

    // Capture the compare result on the request beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_hit <= w_in_use && (r_key == i_cmp_key);
        end
    end

    // Shift the key toward or away from the front
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            unique case (i_ctl.mode)
                MODE_NONE: begin
                    r_key <= r_key;
                end
                MODE_MTF: begin
                    if (o_hi_seen) r_key <= i_prev_key;
                end
                MODE_INSERT: begin
                    if (w_le_count) r_key <= i_prev_key;
                end
                MODE_REMOVE: begin
                    if (o_lo_seen) r_key <= i_next_key;
                end
            endcase
        end
    end

endmodule

>>> design/move_to_front_set.sv
// Top level of the move-to-front key set: controller, chain of slot cells
// and result register. Uses mtfs_pkg and mtfs_cell.
//
// Usage:
//   Request channel: i_valid / o_stall carry i_req_type (lookup, add,
//   remove) and i_key. A beat is taken when i_valid is high and o_stall low.
//   Result channel: o_valid / i_stall carry o_found, o_full_drop and
//   o_occupancy, one result beat per request, in request order.
//   Timing: on the request beat every cell compares its key with i_key and
//   registers a hit; then, in the update state, the hit flags ripple along
//   the chain, each cell takes its neighbor's key or holds, and the result
//   is written to the output register, which drives o_valid. No new request
//   is taken until that update is done.
//   Stall: while the output register holds an untaken result, the update
//   cycle waits and o_stall stays high; nothing is lost.
//   Reset: i_rst_n low at a clock edge empties the set (count zero) and
//   clears the result valid flag. Slot keys are left as they are, since only
//   slots below the count can ever report a hit.
module move_to_front_set
    import mtfs_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_req_type,
    input  logic [KEY_PORT_W-1:0] i_key,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_found,
    output logic                  o_full_drop,
    output logic [OCC_W-1:0]      o_occupancy
);

    localparam int KW = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
    localparam int CW = $clog2(DEPTH + 1);

    t_state        r_state, n_state;
    logic [1:0]    r_req;
    logic [KW-1:0] r_key;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid;
    logic          r_found, n_found;
    logic          r_drop, n_drop;
    logic [CW-1:0] r_occ;

    t_cell_ctl     w_ctl;
    logic          w_accept;
    logic          w_do_upd;
    logic          w_hit_any;
    logic          w_full;

    logic [KW-1:0] w_key [DEPTH];
    logic          w_hi  [DEPTH+1];
    logic          w_lo  [DEPTH];

    assign w_accept  = i_valid && !o_stall;
    assign w_do_upd  = (r_state == ST_UPD) && (!r_out_valid || !i_stall);
    assign w_full    = (r_count == CW'(DEPTH));
    assign w_hit_any = w_hi[0] | w_lo[DEPTH-1];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_UPD;
            ST_UPD:  if (w_do_upd) n_state = ST_IDLE;
        endcase
    end

    // Outputs: cell control, stall and the next result
    always_comb begin
        o_stall    = (r_state != ST_IDLE);
        w_ctl.cmp  = w_accept;
        w_ctl.upd  = w_do_upd;
        w_ctl.mode = MODE_NONE;
        n_count    = r_count;
        n_found    = 1'b0;
        n_drop     = 1'b0;
        unique case (r_req)
            REQ_LOOKUP: begin
                n_found = w_hit_any;
                if (w_hit_any) w_ctl.mode = MODE_MTF;
            end
            REQ_ADD: begin
                n_found = w_hit_any;
                if (w_hit_any) begin
                    w_ctl.mode = MODE_MTF;
                end else if (!w_full) begin
                    w_ctl.mode = MODE_INSERT;
                    n_count    = r_count + 1'b1;
                end else begin
                    n_drop = 1'b1;
                end
            end
            REQ_REMOVE: begin
                n_found = w_hit_any;
                if (w_hit_any) begin
                    w_ctl.mode = MODE_REMOVE;
                    n_count    = r_count - 1'b1;
                end
            end
            default: begin
                n_found = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_do_upd) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req_type;
            r_key <= i_key[KW-1:0];
        end
        if (w_do_upd) begin
            r_found <= n_found;
            r_drop  <= n_drop;
            r_occ   <= n_count;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_found     = r_found;
    assign o_full_drop = r_drop;
    assign o_occupancy = OCC_W'(r_occ);

    // Chain ends
    assign w_hi[DEPTH] = 1'b0;

    // Slot cells, front first
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [KW-1:0] w_prev;
        logic [KW-1:0] w_next;
        logic          w_lo_in;

        if (gi == 0) begin : g_front
            assign w_prev  = r_key;
            assign w_lo_in = 1'b0;
        end else begin : g_mid
            assign w_prev  = w_key[gi-1];
            assign w_lo_in = w_lo[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_back
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_key[gi+1];
        end

        mtfs_cell #(
            .IDX (gi),
            .KW  (KW),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_count    (r_count),
            .i_cmp_key  (i_key[KW-1:0]),
            .i_prev_key (w_prev),
            .i_next_key (w_next),
            .i_hi_seen  (w_hi[gi+1]),
            .i_lo_seen  (w_lo_in),
            .o_key      (w_key[gi]),
            .o_hi_seen  (w_hi[gi]),
            .o_lo_seen  (w_lo[gi])
        );
    end

endmodule

>>> design/mtfs_check.sv
// Port-level checker for the move-to-front key set, bound to its top level.
// Uses mtfs_pkg for the field widths.
module mtfs_check
    import mtfs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic [1:0]            i_req_type,
    input logic [KEY_PORT_W-1:0] i_key,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic                  o_found,
    input logic                  o_full_drop,
    input logic [OCC_W-1:0]      o_occupancy
);

    // A request beat blocks the next request beat
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request taken in the cycle after a request beat");

    // A stalled result beat holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_found)
            && $stable(o_full_drop) && $stable(o_occupancy)))
        else $error("stalled result beat changed");

    // A dropped add never reports a held key
    a_drop_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_found && o_full_drop))
        else $error("result both found and dropped");

    // A drop only happens with every slot in use
    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_full_drop) |-> (o_occupancy == OCC_W'(DEPTH)))
        else $error("drop reported with free slots");

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind move_to_front_set mtfs_check #(.DEPTH(DEPTH)) u_mtfs_check (.*);
